[design/hfa_pkg.sv]
package hfa_pkg;

    // payload widths of the stream fields
    localparam int OPCODE_W     = 2;
    localparam int LOAD_IDX_W   = 4;
    localparam int SIZE_VALUE_W = 16;

    // configuration port
    localparam int FIT_MODE_W   = 2;
    localparam int HOLE_COUNT_W = 5;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 5;

    typedef logic [OPCODE_W-1:0]    opcode_t;
    typedef logic [FIT_MODE_W-1:0]  fit_mode_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    // item opcodes
    localparam opcode_t OP_LOAD    = 2'd0;
    localparam opcode_t OP_ALLOC   = 2'd1;
    localparam opcode_t OP_RESTORE = 2'd2;

    // placement policies, unused code behaves as first fit
    localparam fit_mode_t FIT_FIRST = 2'd0;
    localparam fit_mode_t FIT_BEST  = 2'd1;
    localparam fit_mode_t FIT_WORST = 2'd2;

    // register indexes
    localparam cfg_index_t REG_FIT_MODE   = 1'b0;
    localparam cfg_index_t REG_HOLE_COUNT = 1'b1;

    // controls from the sequencer to the pick tracker
    typedef struct packed {
        logic      clear;
        logic      upd;
        fit_mode_t mode;
    } pick_ctrl_t;

endpackage

[design/hfa_in_if.sv]
interface hfa_in_if;
    import hfa_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [OPCODE_W-1:0]     opcode;
    logic [LOAD_IDX_W-1:0]   load_index;
    logic [SIZE_VALUE_W-1:0] size_value;

    modport source (output valid, opcode, load_index, size_value, input ready);
    modport sink   (input valid, opcode, load_index, size_value, output ready);
endinterface

[design/hfa_out_if.sv]
interface hfa_out_if;
    import hfa_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    granted;
    logic [LOAD_IDX_W-1:0]   chosen_index;
    logic [SIZE_VALUE_W-1:0] hole_size_before;

    modport source (output valid, granted, chosen_index, hole_size_before, input ready);
    modport sink   (input valid, granted, chosen_index, hole_size_before, output ready);
endinterface

[design/hfa_ram.sv]
module hfa_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/hfa_pick.sv]
module hfa_pick #(
    parameter int IDX_W     = 4,
    parameter int SIZE_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  hfa_pkg::pick_ctrl_t       ctrl,
    input  logic [SIZE_BITS-1:0]      req,
    input  logic [IDX_W-1:0]          idx,
    input  logic [SIZE_BITS-1:0]      data,
    output logic                      found,
    output logic [IDX_W-1:0]          pick_idx,
    output logic [SIZE_BITS-1:0]      pick_size
);
    import hfa_pkg::*;

    logic                 have_reg;
    logic                 have_next;
    logic [IDX_W-1:0]     best_idx_reg;
    logic [IDX_W-1:0]     best_idx_next;
    logic [SIZE_BITS-1:0] best_reg;
    logic [SIZE_BITS-1:0] best_next;
    logic                 fits;
    logic                 take;

    assign fits = (data >= req);

    always_comb
    begin
        case (ctrl.mode)
            FIT_BEST:  take = fits && (!have_reg || (data < best_reg));
            FIT_WORST: take = !have_reg || (data > best_reg);
            default:   take = fits && !have_reg;
        endcase
    end

    always_comb
    begin
        have_next     = have_reg;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        if (ctrl.clear)
        begin
            have_next = 1'b0;
        end
        else if (ctrl.upd && take)
        begin
            have_next     = 1'b1;
            best_next     = data;
            best_idx_next = idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
        end
        else
        begin
            have_reg <= have_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
    end

    // worst fit keeps the largest hole and checks the request only at the end
    assign found     = (ctrl.mode == FIT_WORST) ? (have_reg && (best_reg >= req)) : have_reg;
    assign pick_idx  = best_idx_reg;
    assign pick_size = best_reg;

endmodule

[design/hole_fit_allocator_top.sv]
// hole_fit_allocator_top: first, best or worst fit placement over a table of free holes
// allocate: scan, drain, then finish, which waits for a free output slot; no new item until idle;
//   the scan reads n = min(hole_count, HOLES) entries one a cycle; hole_count 0 skips the scan
// load: written at the accept edge; restore: copies all HOLES entries back, one entry copied a cycle
// reset: clears sequencer, output slot, fit_mode to first fit and hole_count to 16;
//   both memories stay unwritten and need loading before use
module hole_fit_allocator_top #(
    parameter int HOLES     = 16,
    parameter int SIZE_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [hfa_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [hfa_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    hfa_in_if.sink                       in_ch,
    hfa_out_if.source                    out_ch
);
    import hfa_pkg::*;

    localparam int IDX_W = (HOLES > 1) ? $clog2(HOLES) : 1;
    localparam int CNT_W = $clog2(HOLES + 1);

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;  // issuing hole reads
    localparam logic [2:0] ST_DRAIN  = 3'd2;  // last read data returns
    localparam logic [2:0] ST_FINISH = 3'd3;  // write back and hand off result
    localparam logic [2:0] ST_COPY   = 3'd4;  // restore: read saved, write hole
    localparam logic [2:0] ST_CDRAIN = 3'd5;  // restore: last write

    logic [2:0]               state_reg;
    logic [2:0]               state_next;
    logic [IDX_W-1:0]         cnt_reg;
    logic [IDX_W-1:0]         cnt_next;
    logic                     pend_reg;
    logic [IDX_W-1:0]         pend_idx_reg;
    logic [SIZE_BITS-1:0]     req_reg;
    logic [SIZE_BITS-1:0]     req_next;

    logic [FIT_MODE_W-1:0]    fit_mode_reg;
    logic [HOLE_COUNT_W-1:0]  hole_count_reg;

    logic                     out_valid_reg;
    logic                     granted_reg;
    logic [LOAD_IDX_W-1:0]    chosen_index_reg;
    logic [SIZE_VALUE_W-1:0]  size_before_reg;

    logic                     in_beat;
    logic                     load_ok;
    logic [CNT_W-1:0]         n_use;
    logic [CNT_W-1:0]         last_idx;
    logic                     scan_last;
    logic                     copy_last;
    logic                     slot_free;
    logic                     finish_go;

    // hole memory ports
    logic                     hole_we;
    logic [IDX_W-1:0]         hole_waddr;
    logic [SIZE_BITS-1:0]     hole_wdata;
    logic [SIZE_BITS-1:0]     hole_rdata;

    // saved copy ports
    logic                     saved_we;
    logic [SIZE_BITS-1:0]     saved_rdata;

    // pick tracker
    pick_ctrl_t               pick_ctrl;
    logic                     pick_found;
    logic [IDX_W-1:0]         pick_idx;
    logic [SIZE_BITS-1:0]     pick_size;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_beat     = in_ch.valid && in_ch.ready;
    assign load_ok     = (int'(in_ch.load_index) < HOLES);

    // entries in use, saturated at the table depth
    assign n_use     = (int'(hole_count_reg) > HOLES) ? CNT_W'(HOLES) : CNT_W'(hole_count_reg);
    assign last_idx  = n_use - CNT_W'(1);
    assign scan_last = (CNT_W'(cnt_reg) == last_idx);
    assign copy_last = (cnt_reg == IDX_W'(HOLES - 1));

    // the output slot takes a new result once the previous beat has left
    assign slot_free = !out_valid_reg || out_ch.ready;
    assign finish_go = (state_reg == ST_FINISH) && slot_free;

    // configuration registers; the user must write them only while idle, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_mode_reg   <= FIT_FIRST;
            hole_count_reg <= HOLE_COUNT_W'(16);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FIT_MODE:   fit_mode_reg   <= cfg_wdata[FIT_MODE_W-1:0];
                REG_HOLE_COUNT: hole_count_reg <= cfg_wdata[HOLE_COUNT_W-1:0];
                default:        ;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        req_next   = req_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    cnt_next = '0;
                    if (in_ch.opcode == OP_ALLOC)
                    begin
                        req_next   = SIZE_BITS'(in_ch.size_value);
                        // no holes in use: nothing to scan, the request waits
                        state_next = (n_use == '0) ? ST_FINISH : ST_SCAN;
                    end
                    else if (in_ch.opcode == OP_RESTORE)
                    begin
                        state_next = ST_COPY;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + IDX_W'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_COPY:
            begin
                if (copy_last)
                begin
                    state_next = ST_CDRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + IDX_W'(1);
                end
            end
            ST_CDRAIN:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // a read issued this cycle returns data next cycle
            pend_reg  <= (state_reg == ST_SCAN) || (state_reg == ST_COPY);
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg      <= cnt_next;
        req_reg      <= req_next;
        pend_idx_reg <= cnt_reg;
    end

    // hole memory write port: load at accept, restore copy, or allocate write back;
    // the states keep these apart, and every write lands before the next scan reads
    always_comb
    begin
        hole_we    = 1'b0;
        hole_waddr = pend_idx_reg;
        hole_wdata = saved_rdata;
        if (state_reg == ST_IDLE)
        begin
            hole_we    = in_beat && (in_ch.opcode == OP_LOAD) && load_ok;
            hole_waddr = IDX_W'(in_ch.load_index);
            hole_wdata = SIZE_BITS'(in_ch.size_value);
        end
        else if ((state_reg == ST_COPY) || (state_reg == ST_CDRAIN))
        begin
            hole_we = pend_reg;
        end
        else if (state_reg == ST_FINISH)
        begin
            hole_we    = finish_go && pick_found;
            hole_waddr = pick_idx;
            hole_wdata = pick_size - req_reg;
        end
    end

    assign saved_we = (state_reg == ST_IDLE) && hole_we;

    hfa_ram #(
        .DEPTH (HOLES),
        .WIDTH (SIZE_BITS)
    ) u_hole_ram (
        .clk   (clk),
        .we    (hole_we),
        .waddr (hole_waddr),
        .wdata (hole_wdata),
        .raddr (cnt_reg),
        .rdata (hole_rdata)
    );

    hfa_ram #(
        .DEPTH (HOLES),
        .WIDTH (SIZE_BITS)
    ) u_saved_ram (
        .clk   (clk),
        .we    (saved_we),
        .waddr (hole_waddr),
        .wdata (hole_wdata),
        .raddr (cnt_reg),
        .rdata (saved_rdata)
    );

    // the tracker sees each scanned entry as its read data returns
    assign pick_ctrl.clear = in_beat && (in_ch.opcode == OP_ALLOC);
    assign pick_ctrl.upd   = pend_reg && ((state_reg == ST_SCAN) || (state_reg == ST_DRAIN));
    assign pick_ctrl.mode  = fit_mode_reg;

    hfa_pick #(
        .IDX_W     (IDX_W),
        .SIZE_BITS (SIZE_BITS)
    ) u_pick (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (pick_ctrl),
        .req       (req_reg),
        .idx       (pend_idx_reg),
        .data      (hole_rdata),
        .found     (pick_found),
        .pick_idx  (pick_idx),
        .pick_size (pick_size)
    );

    // output slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish_go)
        begin
            granted_reg      <= pick_found;
            chosen_index_reg <= pick_found ? LOAD_IDX_W'(pick_idx) : '0;
            size_before_reg  <= pick_found ? SIZE_VALUE_W'(pick_size) : '0;
        end
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.granted          = granted_reg;
    assign out_ch.chosen_index     = chosen_index_reg;
    assign out_ch.hole_size_before = size_before_reg;

    // the decision is taken only after the last scanned entry has arrived
    a_finish_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |-> !pend_reg)
        else $error("allocation decided with a read still in flight");

    // no hole write may disturb a scan in progress
    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCAN) || (state_reg == ST_DRAIN)) |-> !hole_we)
        else $error("hole memory written during a scan");

    // a waiting request reports zero index and size
    a_wait_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.granted) |->
            ((out_ch.chosen_index == '0) && (out_ch.hole_size_before == '0)))
        else $error("waiting result carries a nonzero index or size");

    // an allocate beat starts a scan, or goes straight to the decision with no holes
    a_alloc_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && (in_ch.opcode == OP_ALLOC)) |=>
            ((state_reg == ST_SCAN) || (state_reg == ST_FINISH)))
        else $error("allocate beat did not start a scan");

    // a result never overwrites one that has not left
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |=> ($stable(granted_reg) && $stable(size_before_reg)))
        else $error("pending result overwritten");

endmodule
